FILE: rtl/core/ppm_pkg.sv
// Shared types and constants for the peak programme meter.
// Holds the port item structs, the queue entry formats and the fixed-point constants.
// No dependencies.
package ppm_pkg;

    // Field and register widths
    localparam int CH_FIELD_W = 3;
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int DB_W       = 16;
    localparam int LEVEL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd2;

    // Register reset values
    localparam logic [COEF_W-1:0]     ATTACK_RST  = 24'd76720;
    localparam logic [COEF_W-1:0]     RELEASE_RST = 24'd513;
    localparam logic signed [DB_W-1:0] FLOOR_RST  = 16'sh9C00;   // -100 dB in Q8.8

    // Fixed-point constants
    localparam logic [COEF_W:0]  ONE_Q24         = 25'h1000000;
    localparam logic [18:0]      DB_PER_LOG2_Q16 = 19'd394566;  // 20*log10(2), Q.16
    localparam logic [39:0]      ROUND_Q24       = 40'h0000800000;
    localparam logic [15:0]      DB_MAG_MAX      = 16'd32768;

    // dB converter pipeline shape
    localparam int NORM_STAGES = 5;    // shift by 16, 8, 4, 2, 1
    localparam int SQ_STAGES   = 16;   // one fraction bit of log2 per stage

    // Queue depths
    localparam int WORK_Q_DEPTH = 4;
    localparam int RES_Q_DEPTH  = 4;

    // Input item as seen on the push side
    typedef struct packed {
        logic [CH_FIELD_W-1:0]      channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_end;
    } in_item_t;

    // Result item as seen on the pop side
    typedef struct packed {
        logic [CH_FIELD_W-1:0]  out_channel;
        logic signed [DB_W-1:0] level_db;
    } result_t;

    // Classified item between front and back
    typedef struct packed {
        logic [CH_FIELD_W-1:0] channel;
        logic [LEVEL_W-1:0]    mag;
        logic                  block_end;
    } work_t;

    // Block peak handed to the dB converter
    typedef struct packed {
        logic                  valid;
        logic [CH_FIELD_W-1:0] channel;
        logic [LEVEL_W-1:0]    peak;
    } peak_req_t;

endpackage

FILE: rtl/core/ppm_fifo.sv
// Small synchronous queue with registered storage and a combinational head.
// Used for the work queue and the result queue. No package dependency.
module ppm_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   rd_ptr_reg;
    logic             do_wr;
    logic             do_rd;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                   (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg[PTR_W-1:0]];

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg[PTR_W-1:0]] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/ppm_front.sv
// Front end: takes sample items, drops those on absent channels, forms |sample| in Q1.31
// and queues the classified item for the back end. Uses ppm_pkg and ppm_fifo.
module ppm_front #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ppm_pkg::in_item_t  item,
    input  logic               q_pop,
    output logic               q_empty,
    output ppm_pkg::work_t     q_item
);

    logic                             ch_ok;
    logic [ppm_pkg::SAMPLE_W:0]       neg_sample;
    logic [ppm_pkg::SAMPLE_W-1:0]     mag24;
    ppm_pkg::work_t                   work;
    logic [$bits(ppm_pkg::work_t)-1:0] q_rd_data;

    // Classify: items on channels beyond the instance are dropped
    assign ch_ok = (32'(item.channel) < NUM_CHANNELS);

    // Form the magnitude; the most negative sample maps to 2^23
    assign neg_sample = ppm_pkg::ONE_Q24 - {1'b0, $unsigned(item.sample)};
    assign mag24      = item.sample[ppm_pkg::SAMPLE_W-1] ? neg_sample[ppm_pkg::SAMPLE_W-1:0]
                                                         : $unsigned(item.sample);

    always_comb
    begin
        work.channel   = item.channel;
        work.mag       = {mag24, 8'd0};
        work.block_end = item.block_end;
    end

    ppm_fifo #(
        .DEPTH (ppm_pkg::WORK_Q_DEPTH),
        .WIDTH ($bits(ppm_pkg::work_t))
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && ch_ok),
        .wr_data (work),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    assign q_item = q_rd_data;

endmodule

FILE: rtl/core/ppm_level.sv
// Back end, level part: per-channel attack/release smoothing and block peak tracking.
// State lives in two channel memories with valid bits and last-write forwarding.
// Uses ppm_pkg.
module ppm_level #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          q_empty,
    input  ppm_pkg::work_t                q_item,
    output logic                          q_pop,
    input  logic [ppm_pkg::COEF_W-1:0]    attack_coef,
    input  logic [ppm_pkg::COEF_W-1:0]    release_coef,
    output ppm_pkg::peak_req_t            pk
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LW   = ppm_pkg::LEVEL_W;

    logic [LW-1:0]           lvl_mem [0:NUM_CHANNELS-1];
    logic [LW-1:0]           pk_mem  [0:NUM_CHANNELS-1];
    logic [NUM_CHANNELS-1:0] vld_reg;

    logic [CH_W+ppm_pkg::CH_FIELD_W-1:0] head_ext;
    logic [CH_W+ppm_pkg::CH_FIELD_W-1:0] b2_ext;
    logic [CH_W-1:0]         head_idx;
    logic [CH_W-1:0]         b2_idx;

    logic                    b2_valid_reg;
    ppm_pkg::work_t          b2_item_reg;
    logic [LW-1:0]           lvl_rd_reg;
    logic [LW-1:0]           pk_rd_reg;
    logic                    vld_rd_reg;

    logic                    lw_valid_reg;
    logic [CH_W-1:0]         lw_idx_reg;
    logic [LW-1:0]           lw_lvl_reg;
    logic [LW-1:0]           lw_pk_reg;

    logic                    commit;
    logic                    fwd;
    logic [LW-1:0]           cur_lvl;
    logic [LW-1:0]           cur_pk;
    logic                    rel;
    logic [LW-1:0]           op_a;
    logic [ppm_pkg::COEF_W:0] op_b;
    logic [LW+ppm_pkg::COEF_W:0] prod;
    logic [LW-1:0]           lvl_next;
    logic [LW-1:0]           pk_next;
    logic [LW-1:0]           pk_wr;

    assign head_ext = {{CH_W{1'b0}}, q_item.channel};
    assign b2_ext   = {{CH_W{1'b0}}, b2_item_reg.channel};
    assign head_idx = head_ext[CH_W-1:0];
    assign b2_idx   = b2_ext[CH_W-1:0];

    assign q_pop  = adv && !q_empty;
    assign commit = adv && b2_valid_reg;

    // Pick up the latest state: last write wins, unwritten entries read as zero
    assign fwd     = lw_valid_reg && (lw_idx_reg == b2_idx);
    assign cur_lvl = fwd ? lw_lvl_reg : (vld_rd_reg ? lvl_rd_reg : '0);
    assign cur_pk  = fwd ? lw_pk_reg  : (vld_rd_reg ? pk_rd_reg  : '0);

    // Release decays the level; attack moves it towards the magnitude by a*(m - level)
    assign rel  = cur_lvl > b2_item_reg.mag;
    assign op_a = rel ? cur_lvl : (b2_item_reg.mag - cur_lvl);
    assign op_b = rel ? (ppm_pkg::ONE_Q24 - {1'b0, release_coef}) : {1'b0, attack_coef};
    assign prod = op_a * op_b;

    always_comb
    begin
        if (rel)
        begin
            lvl_next = prod[LW+ppm_pkg::COEF_W-1:ppm_pkg::COEF_W];
        end
        else
        begin
            lvl_next = cur_lvl + prod[LW+ppm_pkg::COEF_W-1:ppm_pkg::COEF_W];
        end
        pk_next = (lvl_next > cur_pk) ? lvl_next : cur_pk;
        pk_wr   = b2_item_reg.block_end ? '0 : pk_next;
    end

    // Hand the block peak to the dB converter on end of block
    always_comb
    begin
        pk.valid   = b2_valid_reg && b2_item_reg.block_end;
        pk.channel = b2_item_reg.channel;
        pk.peak    = pk_next;
    end

    // Move the head item into the update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b2_valid_reg <= !q_empty;
        end
    end

    // Read state for the head item, write back the updated state
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b2_item_reg <= q_item;
            lvl_rd_reg  <= lvl_mem[head_idx];
            pk_rd_reg   <= pk_mem[head_idx];
            vld_rd_reg  <= vld_reg[head_idx];
        end
        if (commit)
        begin
            lvl_mem[b2_idx] <= lvl_next;
            pk_mem[b2_idx]  <= pk_wr;
        end
    end

    // Mark written entries and hold the last write for forwarding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            lw_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            vld_reg[b2_idx] <= 1'b1;
            lw_valid_reg    <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            lw_idx_reg <= b2_idx;
            lw_lvl_reg <= lvl_next;
            lw_pk_reg  <= pk_wr;
        end
    end

endmodule

FILE: rtl/core/ppm_db.sv
// Back end, conversion part: block peak (Q1.31) to dB (Q8.8) with flooring.
// Pipeline: capture, five normalising shift stages, sixteen squaring stages for the
// log2 fraction, magnitude, scale by 20*log10(2), saturate and floor. Uses ppm_pkg.
module ppm_db (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  ppm_pkg::peak_req_t            pk,
    input  logic signed [ppm_pkg::DB_W-1:0] floor_db,
    output logic                          res_valid,
    output ppm_pkg::result_t              res
);

    localparam int NORM_LAST = ppm_pkg::NORM_STAGES;
    localparam int PIPE_LAST = ppm_pkg::NORM_STAGES + ppm_pkg::SQ_STAGES;
    localparam int CW        = ppm_pkg::CH_FIELD_W;

    logic          v_reg    [0:PIPE_LAST];
    logic [CW-1:0] ch_reg   [0:PIPE_LAST];
    logic          zero_reg [0:PIPE_LAST];
    logic [4:0]    sh_reg   [0:PIPE_LAST];
    logic [31:0]   y_reg    [0:PIPE_LAST];
    logic [15:0]   frac_reg [0:PIPE_LAST];

    logic          l_valid_reg;
    logic [CW-1:0] l_ch_reg;
    logic          l_zero_reg;
    logic          l_nonneg_reg;
    logic [20:0]   l_mag_reg;

    logic          m_valid_reg;
    logic [CW-1:0] m_ch_reg;
    logic          m_zero_reg;
    logic          m_nonneg_reg;
    logic [15:0]   m_dbmag_reg;

    logic          o_valid_reg;
    ppm_pkg::result_t o_res_reg;

    logic [20:0]   l_mag_next;
    logic [39:0]   m_prod;
    logic [39:0]   m_sum;
    logic [15:0]   f_mag;
    logic signed [16:0] f_db;
    logic signed [16:0] f_floor;
    logic signed [16:0] f_res;

    for (genvar k = 0; k <= PIPE_LAST; k++)
    begin : g_stage
        logic          v_next;
        logic [CW-1:0] ch_next;
        logic          zero_next;
        logic [4:0]    sh_next;
        logic [31:0]   y_next;
        logic [15:0]   frac_next;

        if (k == 0)
        begin : g_in
            // Capture the peak
            always_comb
            begin
                v_next    = pk.valid;
                ch_next   = pk.channel;
                zero_next = (pk.peak == '0);
                sh_next   = '0;
                y_next    = pk.peak;
                frac_next = '0;
            end
        end
        else if (k <= NORM_LAST)
        begin : g_norm
            localparam int SH = 32 >> k;
            // Shift up while the top bits are clear, count the shift
            always_comb
            begin
                v_next    = v_reg[k-1];
                ch_next   = ch_reg[k-1];
                zero_next = zero_reg[k-1];
                frac_next = frac_reg[k-1];
                if (y_reg[k-1][31 -: SH] == '0)
                begin
                    y_next  = y_reg[k-1] << SH;
                    sh_next = sh_reg[k-1] + 5'(SH);
                end
                else
                begin
                    y_next  = y_reg[k-1];
                    sh_next = sh_reg[k-1];
                end
            end
        end
        else
        begin : g_sq
            logic [63:0] sq;
            logic [32:0] t;
            // Square the mantissa; an overflow past 2.0 yields a fraction bit
            always_comb
            begin
                sq        = y_reg[k-1] * y_reg[k-1];
                t         = sq[63:31];
                v_next    = v_reg[k-1];
                ch_next   = ch_reg[k-1];
                zero_next = zero_reg[k-1];
                sh_next   = sh_reg[k-1];
                y_next    = t[32] ? t[32:1] : t[31:0];
                frac_next = {frac_reg[k-1][14:0], t[32]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ch_reg[k]   <= ch_next;
                zero_reg[k] <= zero_next;
                sh_reg[k]   <= sh_next;
                y_reg[k]    <= y_next;
                frac_reg[k] <= frac_next;
            end
        end
    end

    // Form |log2| in Q.16: shift count is the integer part
    assign l_mag_next = {sh_reg[PIPE_LAST], 16'd0} - {5'd0, frac_reg[PIPE_LAST]};

    // Scale to dB with rounding
    assign m_prod = l_mag_reg * ppm_pkg::DB_PER_LOG2_Q16;
    assign m_sum  = m_prod + ppm_pkg::ROUND_Q24;

    // Saturate, negate and floor
    always_comb
    begin
        f_mag   = (m_dbmag_reg > ppm_pkg::DB_MAG_MAX) ? ppm_pkg::DB_MAG_MAX : m_dbmag_reg;
        f_floor = 17'(floor_db);
        if (m_zero_reg)
        begin
            f_db = -17'sd32768;
        end
        else if (m_nonneg_reg)
        begin
            f_db = '0;
        end
        else
        begin
            f_db = -$signed({1'b0, f_mag});
        end
        f_res = (f_db < f_floor) ? f_floor : f_db;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            l_valid_reg <= v_reg[PIPE_LAST];
            m_valid_reg <= l_valid_reg;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_ch_reg              <= ch_reg[PIPE_LAST];
            l_zero_reg            <= zero_reg[PIPE_LAST];
            l_nonneg_reg          <= (sh_reg[PIPE_LAST] == '0);
            l_mag_reg             <= l_mag_next;
            m_ch_reg              <= l_ch_reg;
            m_zero_reg            <= l_zero_reg;
            m_nonneg_reg          <= l_nonneg_reg;
            m_dbmag_reg           <= m_sum[39:24];
            o_res_reg.out_channel <= m_ch_reg;
            o_res_reg.level_db    <= f_res[15:0];
        end
    end

    assign res_valid = o_valid_reg;
    assign res       = o_res_reg;

endmodule

FILE: rtl/core/ppm_peak_level_meter.sv
// Top level of the multichannel peak programme meter.
// Holds the configuration registers and joins front end, level stage, dB converter
// and result queue. Uses ppm_pkg, ppm_front, ppm_level, ppm_db and ppm_fifo.
//
// Usage:
//   Input is a queue: an item {channel, sample, block_end} is taken on a clock edge
//   with push high and full low. Results are a queue too: while empty is low the
//   oldest item {out_channel, level_db} is on result, and pop takes it.
//   Items on channels at or above NUM_CHANNELS are taken and discarded.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (attack,
//   release, floor) at once; write only while no items are in flight.
//   Throughput: one item per cycle sustained while the result queue is not full, any
//   channel order, including the same channel back to back; the per-channel update uses
//   forwarding of the last write around the registered state read.
//   A block_end item passes the work queue, the update stage, the 21-stage
//   normalise-and-square log2 pipeline and the scaling stages before its result is queued.
//   Stall: when the result queue fills, the whole back end holds; the work queue
//   then fills and full rises. No item is lost.
//   Reset: levels and block peaks read as zero, registers take default values,
//   both queues empty. No clearing pass is needed.
module ppm_peak_level_meter #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  ppm_pkg::in_item_t                 item,
    output logic                              empty,
    input  logic                              pop,
    output ppm_pkg::result_t                  result,
    input  logic                              cfg_wr_en,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [ppm_pkg::COEF_W-1:0]      attack_coef_reg;
    logic [ppm_pkg::COEF_W-1:0]      release_coef_reg;
    logic signed [ppm_pkg::DB_W-1:0] floor_db_reg;

    logic               q_pop;
    logic               q_empty;
    ppm_pkg::work_t     q_item;
    ppm_pkg::peak_req_t pk;
    logic               adv;
    logic               db_valid;
    ppm_pkg::result_t   db_res;
    logic               res_full;
    logic [$bits(ppm_pkg::result_t)-1:0] res_rd_data;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coef_reg  <= ppm_pkg::ATTACK_RST;
            release_coef_reg <= ppm_pkg::RELEASE_RST;
            floor_db_reg     <= ppm_pkg::FLOOR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ppm_pkg::CFG_ATTACK:  attack_coef_reg  <= cfg_wdata;
                ppm_pkg::CFG_RELEASE: release_coef_reg <= cfg_wdata;
                ppm_pkg::CFG_FLOOR:   floor_db_reg     <= $signed(cfg_wdata[ppm_pkg::DB_W-1:0]);
                default:              ;
            endcase
        end
    end

    // Hold the back end while the result queue is full
    assign adv = !res_full;

    ppm_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_pop   (q_pop),
        .q_empty (q_empty),
        .q_item  (q_item)
    );

    ppm_level #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_level (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .q_empty      (q_empty),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .attack_coef  (attack_coef_reg),
        .release_coef (release_coef_reg),
        .pk           (pk)
    );

    ppm_db u_db (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .pk        (pk),
        .floor_db  (floor_db_reg),
        .res_valid (db_valid),
        .res       (db_res)
    );

    ppm_fifo #(
        .DEPTH (ppm_pkg::RES_Q_DEPTH),
        .WIDTH ($bits(ppm_pkg::result_t))
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (adv && db_valid),
        .wr_data (db_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign result = res_rd_data;

endmodule

FILE: rtl/core/ppm_checker.sv
// Port-level checks for the peak programme meter, bound to the top level.
// Uses ppm_pkg for the result item type.
module ppm_checker #(
    parameter int NUM_CHANNELS = 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input ppm_pkg::result_t result
);

    // Nothing to deliver straight after reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Input backpressure only arises from a backed-up result queue
    a_full_needs_results: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full raised while no result is waiting");

    // Reported channels exist in this instance
    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.out_channel < NUM_CHANNELS))
        else $error("result for a channel outside the instance");

    // A waiting item stays put until taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

endmodule

bind ppm_peak_level_meter ppm_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_ppm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

FILE: tb/testbench.sv
// Self-checking testbench for ppm_peak_level_meter.
// Directed stimulus table, then randomised phases over several register settings.
// A built-in level/dB predictor checks every result. Depends on ppm_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS        = 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PIPE_SETTLE     = 40;     // dB pipeline latency plus queue slack
    localparam int HOLDOFF_CYCLES  = 300;

    localparam logic [63:0] UNITY_Q24         = 64'd16777216;
    localparam logic [63:0] DB_PER_OCTAVE_Q16 = 64'd394566;
    localparam logic [63:0] HALF_Q24          = 64'd8388608;

    // Spare register index with no register behind it
    localparam logic [ppm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // One directed row: item plus an optional hand-written level
    typedef struct packed {
        logic [2:0]         channel;
        logic signed [23:0] sample;
        logic               block_end;
        logic               known;
        logic signed [15:0] known_db;
    } stim_row_t;

    // One random phase: register setting, idling and item mix
    typedef struct {
        logic [23:0]        attack;
        logic [23:0]        decay;
        logic signed [15:0] floor_q8;
        bit                 draw_coefs;
        int                 send_idle;
        int                 recv_stall;
        int                 end_pct;
        int                 count;
        bit                 squeeze;
        bit                 pause;
    } phase_t;

    localparam int NUM_ROWS   = 22;
    localparam int NUM_PHASES = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    ppm_pkg::in_item_t item = '0;
    logic empty;
    logic pop = 1'b0;
    ppm_pkg::result_t result;
    logic cfg_wr_en = 1'b0;
    logic [ppm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ppm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor state: registers, per-channel level and block peak
    logic [23:0]        attack_q24 = 24'd76720;
    logic [23:0]        decay_q24 = 24'd513;
    logic signed [15:0] floor_q88 = -16'sd25600;
    logic [31:0]        level_q31 [CHANNELS];
    logic [31:0]        peak_q31 [CHANNELS];

    ppm_pkg::result_t expected_levels [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int levels_checked = 0;
    int mismatch_count = 0;
    int settings_used = 1;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // zero peak after reset reports the floor
        '{3'd0, 24'sd0,       1'b1, 1'b1, -16'sd25600},
        '{3'd7, 24'sd0,       1'b1, 1'b1, -16'sd25600},
        // full-scale extremes, then the most negative sample
        '{3'd1, 24'sh7FFFFF,  1'b0, 1'b0, 16'sd0},
        '{3'd1, 24'sh800000,  1'b0, 1'b0, 16'sd0},
        '{3'd1, 24'sh800000,  1'b1, 1'b0, 16'sd0},
        // tiny peak: saturates below -128 dB, then floored
        '{3'd2, 24'sd1,       1'b1, 1'b0, 16'sd0},
        '{3'd2, -24'sd1,      1'b1, 1'b0, 16'sd0},
        // alternating bit patterns
        '{3'd3, 24'sh555555,  1'b0, 1'b0, 16'sd0},
        '{3'd3, 24'shAAAAAA,  1'b1, 1'b0, 16'sd0},
        // attack then release
        '{3'd4, 24'sh7FFFFF,  1'b0, 1'b0, 16'sd0},
        '{3'd4, 24'sd0,       1'b0, 1'b0, 16'sd0},
        '{3'd4, 24'sd0,       1'b1, 1'b0, 16'sd0},
        // same channel back to back
        '{3'd5, 24'sh7FFFFF,  1'b0, 1'b0, 16'sd0},
        '{3'd5, 24'sh7FFFFF,  1'b0, 1'b0, 16'sd0},
        '{3'd5, 24'sh7FFFFF,  1'b0, 1'b0, 16'sd0},
        '{3'd5, 24'sh800000,  1'b1, 1'b0, 16'sd0},
        // interleaved channels
        '{3'd6, 24'sd4096,    1'b0, 1'b0, 16'sd0},
        '{3'd0, -24'sd4096,   1'b0, 1'b0, 16'sd0},
        '{3'd6, 24'sd0,       1'b1, 1'b0, 16'sd0},
        '{3'd0, 24'sd0,       1'b1, 1'b0, 16'sd0},
        // block made of release steps only
        '{3'd3, 24'sd0,       1'b0, 1'b0, 16'sd0},
        '{3'd3, 24'sd0,       1'b1, 1'b0, 16'sd0}
    };

    phase_t phases [NUM_PHASES] = '{
        '{24'd76720,   24'd513,     -16'sd25600, 1'b0,  0,  0, 15, 150, 1'b0, 1'b0},
        '{24'hFFFFFF,  24'd0,       16'sh8000,   1'b0, 72,  0, 15, 170, 1'b0, 1'b0},
        '{24'd0,       24'hFFFFFF,  16'sd0,      1'b0,  0, 72, 20, 170, 1'b0, 1'b0},
        '{24'd0,       24'd0,       16'sd256,    1'b1, 35, 35, 15, 170, 1'b0, 1'b0},
        '{24'd1,       24'd1,       -16'sd12800, 1'b0,  0,  0, 80, 170, 1'b1, 1'b0},
        '{24'd76720,   24'd513,     -16'sd25600, 1'b1,  0,  0, 15, 170, 1'b0, 1'b1}
    };

    ppm_peak_level_meter #(
        .NUM_CHANNELS(CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .empty(empty),
        .pop(pop),
        .result(result),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    // Count a mismatch and print one line for it
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // Block peak (Q1.31) to dB (Q8.8) via leading one and repeated squaring
    function automatic logic signed [15:0] peak_in_db(input logic [31:0] peak);
        int          msb;
        int          i;
        int          db;
        logic [63:0] y;
        logic [63:0] mag;
        logic [15:0] frac;
        longint      log2_q16;
        if (peak == 32'd0)
            return 16'sh8000;
        msb = 31;
        while (peak[msb] == 1'b0)
            msb--;
        y = 64'(peak) << (31 - msb);
        frac = '0;
        for (i = 15; i >= 0; i--)
        begin
            y = (y * y) >> 31;
            if (y >= 64'h1_0000_0000)
            begin
                y = y >> 1;
                frac[i] = 1'b1;
            end
        end
        log2_q16 = longint'(msb - 31) * 65536 + longint'(frac);
        if (log2_q16 >= 0)
            return 16'sd0;
        mag = 64'(-log2_q16);
        mag = (mag * DB_PER_OCTAVE_Q16 + HALF_Q24) >> 24;
        if (mag > 64'd32768)
            mag = 64'd32768;
        db = -int'(mag);
        return db[15:0];
    endfunction

    // Advance one channel's smoothed level; produce the block level on block_end
    task automatic track_level(input ppm_pkg::in_item_t it, output bit has_level,
                               output ppm_pkg::result_t lvl);
        logic [2:0]         ch;
        logic [23:0]        mag24;
        logic [31:0]        mag_q31;
        logic [31:0]        cur;
        logic [63:0]        updated;
        logic signed [15:0] db;
        ch = it.channel;
        mag24 = it.sample[23] ? 24'(-it.sample) : 24'(it.sample);
        mag_q31 = {mag24, 8'h00};
        cur = level_q31[ch];
        if (cur > mag_q31)
            updated = (64'(cur) * (UNITY_Q24 - 64'(decay_q24))) >> 24;
        else
            updated = (64'(attack_q24) * 64'(mag_q31)
                       + (UNITY_Q24 - 64'(attack_q24)) * 64'(cur)) >> 24;
        level_q31[ch] = updated[31:0];
        if (updated[31:0] > peak_q31[ch])
            peak_q31[ch] = updated[31:0];
        has_level = it.block_end;
        lvl = '0;
        if (it.block_end)
        begin
            db = peak_in_db(peak_q31[ch]);
            if (db < floor_q88)
                db = floor_q88;
            peak_q31[ch] = '0;
            lvl.out_channel = ch;
            lvl.level_db = db;
        end
    endtask

    // Write one register and mirror it in the predictor; caller lowers the enable
    task automatic write_reg(input logic [ppm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppm_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            ppm_pkg::CFG_ATTACK:  attack_q24 = data;
            ppm_pkg::CFG_RELEASE: decay_q24 = data;
            ppm_pkg::CFG_FLOOR:   floor_q88 = data[15:0];
            default:              ;
        endcase
        @(posedge clk);
    endtask

    // Offer one item after a random gap, hold until taken, then predict
    task automatic send_item(input ppm_pkg::in_item_t it, input logic known,
                             input logic signed [15:0] known_db);
        bit               has_level;
        ppm_pkg::result_t lvl;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        track_level(it, has_level, lvl);
        if (has_level)
        begin
            if (known)
                lvl.level_db = known_db;
            expected_levels.push_back(lvl);
        end
    endtask

    // Wait for every pending level, then let item-only work drain out
    task automatic settle_block();
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // Random item: mostly short blocks with a spread of sample magnitudes
    function automatic ppm_pkg::in_item_t draw_item(input int end_pct);
        ppm_pkg::in_item_t  it;
        logic signed [23:0] s;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            case ($urandom_range(2))
                0:       s = 24'sh7FFFFF;
                1:       s = 24'sh800000;
                default: s = 24'sd0;
            endcase
        end
        else if (pick < 30)
            s = 24'($urandom_range(255));
        else if (pick < 50)
            s = 24'($urandom_range(65535));
        else
            s = 24'($urandom);
        if (pick >= 8 && pick < 50 && $urandom_range(1) == 1)
            s = -s;
        it.channel = 3'($urandom_range(CHANNELS - 1));
        it.sample = s;
        it.block_end = ($urandom_range(99) < end_pct);
        return it;
    endfunction

    // Receiver: random stalls, plus a counted hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (holdoff_left > 0)
            begin
                pop <= 1'b0;
                holdoff_left--;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each popped level with the oldest prediction
    always @(posedge clk)
    begin : check_levels
        ppm_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_levels.size() == 0)
                report_mismatch($sformatf("level %0d on channel %0d with nothing pending",
                                          result.level_db, result.out_channel));
            else
            begin
                want = expected_levels.pop_front();
                levels_checked++;
                if (result.out_channel !== want.out_channel)
                    report_mismatch($sformatf("out_channel got %0d, expected %0d",
                                              result.out_channel, want.out_channel));
                if (result.level_db !== want.level_db)
                    report_mismatch($sformatf("level_db ch %0d got %0d, expected %0d",
                                              want.out_channel, result.level_db,
                                              want.level_db));
            end
        end
    end

    // Watchdog: end the run if no handshake happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d levels pending",
                         quiet_cycles, expected_levels.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain and verdict
    initial
    begin : main_flow
        int     r;
        int     p;
        int     n;
        phase_t cur;
        for (r = 0; r < CHANNELS; r++)
        begin
            level_q31[r] = '0;
            peak_q31[r] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset settings
        for (r = 0; r < NUM_ROWS; r++)
            send_item('{directed_rows[r].channel, directed_rows[r].sample,
                        directed_rows[r].block_end},
                      directed_rows[r].known, directed_rows[r].known_db);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            cur = phases[p];
            // Reprogram only once the block has gone quiet
            if (p != 0)
            begin
                push <= 1'b0;
                settle_block();
                if (cur.draw_coefs)
                begin
                    cur.attack = 24'($urandom);
                    cur.decay = 24'($urandom_range(65535));
                    if (p == NUM_PHASES - 1)
                        cur.floor_q8 = 16'(-int'($urandom_range(32768)));
                end
                if (cur.squeeze)
                    write_reg(CFG_SPARE, 24'($urandom));
                write_reg(ppm_pkg::CFG_ATTACK, cur.attack);
                write_reg(ppm_pkg::CFG_RELEASE, cur.decay);
                write_reg(ppm_pkg::CFG_FLOOR, {8'($urandom), cur.floor_q8});
                cfg_wr_en <= 1'b0;
                settings_used++;
            end
            send_idle_pct = cur.send_idle;
            recv_stall_pct = cur.recv_stall;
            for (n = 0; n < cur.count; n++)
            begin
                // Hold the receiver off so the block backs up into full
                if (cur.squeeze && n == 20)
                    holdoff_left = HOLDOFF_CYCLES;
                // Pause the sender until every pending level is out
                if (cur.pause && n == cur.count / 2)
                begin
                    push <= 1'b0;
                    settle_block();
                end
                send_item(draw_item(cur.end_pct), 1'b0, 16'sd0);
            end
        end
        push <= 1'b0;
        settle_block();

        $display("summary: %0d items (%0d directed), %0d register settings, %0d levels checked",
                 items_sent, NUM_ROWS, settings_used, levels_checked);
        $display("summary: coefficient extremes, floors from -128 dB to above 0 dB, %s",
                 "stalls and back-pressure");
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
